/* rtl/bloom_filter_add_query_macros.svh */
// assertion macros for the bloom filter block
`ifndef BLOOM_FILTER_ADD_QUERY_MACROS_SVH
`define BLOOM_FILTER_ADD_QUERY_MACROS_SVH

// property that must hold at every edge outside reset
`define BF_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define BF_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

/* rtl/bfaq_pkg.sv */
`timescale 1ns / 1ps
package bfaq_pkg;
	localparam logic [31:0] SEED = 32'hbc9f1d34;
	localparam logic [31:0] C1 = 32'hcc9e2d51;
	localparam logic [31:0] C2 = 32'h1b873593;
	localparam logic [31:0] N1 = 32'he6546b64;
	localparam logic [31:0] F1 = 32'h85ebca6b;
	localparam logic [31:0] F2 = 32'hc2b2ae35;
	localparam logic [1:0] REG_BIT_COUNT = 2'd0;
	localparam logic [1:0] REG_HASH_COUNT = 2'd1;
	localparam logic MODE_ADD = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE, ST_SCR1, ST_SCR2, ST_SCR3, ST_FIN1, ST_FIN2, ST_FIN3,
		ST_MOD, ST_ACC, ST_CHK, ST_DONE
	} state_t;

	typedef struct packed {
		logic load_word;
		logic scr_mul1;
		logic scr_mul2;
		logic absorb;
		logic fin_start;
		logic fin_mul1;
		logic fin_mul2;
		logic mod_start;
		logic mem_rd;
		logic mem_chk;
		logic probe_next;
		logic clear_key;
	} dp_cmd_t;

	typedef struct packed {
		logic is_last;
		logic mod_done;
		logic probes_zero;
	} dp_sts_t;

	function automatic logic [31:0] rotl(input logic [31:0] x, input int r);
		rotl = (x << r) | (x >> (32 - r));
	endfunction
endpackage

/* rtl/bfaq_ram.sv */
`timescale 1ns / 1ps
module bfaq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

/* rtl/bfaq_ctrl.sv */
`timescale 1ns / 1ps
module bfaq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              clr_busy,
	input  bfaq_pkg::dp_sts_t sts,
	output bfaq_pkg::dp_cmd_t cmd,
	output logic              busy,
	output logic              strobe
);
	bfaq_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= bfaq_pkg::ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			bfaq_pkg::ST_IDLE: if (start && !clr_busy) state_d = bfaq_pkg::ST_SCR1;
			bfaq_pkg::ST_SCR1: state_d = bfaq_pkg::ST_SCR2;
			bfaq_pkg::ST_SCR2: state_d = bfaq_pkg::ST_SCR3;
			bfaq_pkg::ST_SCR3: state_d = sts.is_last ? bfaq_pkg::ST_FIN1 : bfaq_pkg::ST_IDLE;
			bfaq_pkg::ST_FIN1: state_d = bfaq_pkg::ST_FIN2;
			bfaq_pkg::ST_FIN2: state_d = bfaq_pkg::ST_FIN3;
			bfaq_pkg::ST_FIN3: state_d = sts.probes_zero ? bfaq_pkg::ST_DONE : bfaq_pkg::ST_MOD;
			bfaq_pkg::ST_MOD: if (sts.mod_done) state_d = bfaq_pkg::ST_ACC;
			bfaq_pkg::ST_ACC: state_d = bfaq_pkg::ST_CHK;
			bfaq_pkg::ST_CHK: state_d = sts.probes_zero ? bfaq_pkg::ST_DONE : bfaq_pkg::ST_MOD;
			bfaq_pkg::ST_DONE: state_d = bfaq_pkg::ST_IDLE;
			default: state_d = bfaq_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		busy = 1'b1;
		strobe = 1'b0;
		case (state_q)
			bfaq_pkg::ST_IDLE: begin
				busy = clr_busy;
				cmd.load_word = start && !clr_busy;
			end
			bfaq_pkg::ST_SCR1: cmd.scr_mul1 = 1'b1;
			bfaq_pkg::ST_SCR2: cmd.scr_mul2 = 1'b1;
			bfaq_pkg::ST_SCR3: cmd.absorb = 1'b1;
			bfaq_pkg::ST_FIN1: cmd.fin_start = 1'b1;
			bfaq_pkg::ST_FIN2: cmd.fin_mul1 = 1'b1;
			bfaq_pkg::ST_FIN3: begin
				cmd.fin_mul2 = 1'b1;
				cmd.mod_start = !sts.probes_zero;
			end
			bfaq_pkg::ST_MOD: cmd.mem_rd = sts.mod_done;
			bfaq_pkg::ST_ACC: ;
			bfaq_pkg::ST_CHK: begin
				cmd.mem_chk = 1'b1;
				cmd.probe_next = 1'b1;
				cmd.mod_start = !sts.probes_zero;
			end
			bfaq_pkg::ST_DONE: begin
				strobe = 1'b1;
				cmd.clear_key = 1'b1;
			end
			default: ;
		endcase
	end
endmodule

/* rtl/bfaq_dp.sv */
`timescale 1ns / 1ps
module bfaq_dp #(
	parameter int STORE_BITS = 65536
) (
	input  logic              clk,
	input  logic              arst_n,
	input  bfaq_pkg::dp_cmd_t cmd,
	output bfaq_pkg::dp_sts_t sts,
	output logic              clr_busy,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [16:0]       cfg_data,
	input  logic              mode,
	input  logic [31:0]       key_word,
	input  logic [2:0]        byte_count,
	input  logic              last,
	output logic              done_mode,
	output logic              may_contain
);
	localparam int AW = $clog2(STORE_BITS);
	localparam int WORDS = (STORE_BITS + 31) / 32;
	localparam int WA = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int BW = (AW > 5) ? AW : 6;

	logic [16:0] bit_count_q;
	logic [4:0]  hash_count_q;
	logic [31:0] word_q, scr_q, hacc_q, klen_q, ph_q, pstep_q, fin_q;
	logic        last_q, mode_q, allset_q;
	logic [2:0]  cnt_q;
	logic [4:0]  left_q;
	logic        bit_set;

	// config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_count_q <= 17'd65536;
			hash_count_q <= 5'd7;
		end else if (cfg_we) begin
			if (cfg_index == bfaq_pkg::REG_BIT_COUNT) bit_count_q <= cfg_data;
			if (cfg_index == bfaq_pkg::REG_HASH_COUNT) hash_count_q <= cfg_data[4:0];
		end
	end

	logic [2:0] cnt_eff;
	logic [31:0] tail_mask;
	assign cnt_eff = (!last_q || cnt_q > 3'd4) ? 3'd4 : cnt_q;
	always_comb begin
		case (cnt_eff)
			3'd1: tail_mask = 32'h000000ff;
			3'd2: tail_mask = 32'h0000ffff;
			3'd3: tail_mask = 32'h00ffffff;
			3'd4: tail_mask = 32'hffffffff;
			default: tail_mask = 32'h0;
		endcase
	end

	// effective modulus
	logic [20:0] nbits;
	assign nbits = (bit_count_q == 17'd0 || 21'(bit_count_q) > 21'(STORE_BITS)) ?
		21'(STORE_BITS) : 21'(bit_count_q);

	// restoring divider: remainder of ph_q by nbits, one bit a cycle
	logic [21:0] rem_q;
	logic [31:0] div_q;
	logic [5:0]  dcnt_q;
	logic        dbusy_q;
	logic [21:0] rem_sh;
	assign rem_sh = {rem_q[20:0], div_q[31]};

	logic [31:0] hx, hsq, fin_h;
	assign hx = hacc_q ^ klen_q;
	assign hsq = fin_q ^ (fin_q >> 13);
	assign fin_h = fin_q ^ (fin_q >> 16);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hacc_q <= bfaq_pkg::SEED;
			klen_q <= '0;
			left_q <= '0;
			dbusy_q <= 1'b0;
			dcnt_q <= '0;
		end else begin
			if (cmd.absorb) begin
				if (cnt_eff == 3'd4)
					hacc_q <= bfaq_pkg::rotl(hacc_q ^ scr_q, 13) * 32'd5 + bfaq_pkg::N1;
				else if (cnt_eff != 3'd0)
					hacc_q <= hacc_q ^ scr_q;
				klen_q <= klen_q + 32'(cnt_eff);
			end
			if (cmd.fin_start) left_q <= hash_count_q;
			if (cmd.probe_next) left_q <= left_q - 5'd1;
			if (cmd.clear_key) begin
				hacc_q <= bfaq_pkg::SEED;
				klen_q <= '0;
			end
			if (cmd.mod_start) begin
				dbusy_q <= 1'b1;
				dcnt_q <= '0;
			end else if (dbusy_q) begin
				dcnt_q <= dcnt_q + 6'd1;
				if (dcnt_q == 6'd31) dbusy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_word) begin
			word_q <= key_word;
			cnt_q <= byte_count;
			last_q <= last;
			mode_q <= mode;
		end
		if (cmd.scr_mul1) scr_q <= (word_q & tail_mask) * bfaq_pkg::C1;
		if (cmd.scr_mul2) scr_q <= bfaq_pkg::rotl(scr_q, 15) * bfaq_pkg::C2;
		if (cmd.fin_start) fin_q <= (hx ^ (hx >> 16)) * bfaq_pkg::F1;
		if (cmd.fin_mul1) fin_q <= hsq * bfaq_pkg::F2;
		if (cmd.fin_mul2) begin
			ph_q <= fin_h;
			pstep_q <= bfaq_pkg::rotl(fin_h, 15);
			allset_q <= 1'b1;
		end
		if (cmd.mem_chk && !bit_set) allset_q <= 1'b0;
		if (cmd.mod_start) begin
			rem_q <= '0;
			// first probe takes the hash that is being finalized this cycle
			div_q <= cmd.fin_mul2 ? fin_h : (cmd.probe_next ? ph_q + pstep_q : ph_q);
			if (cmd.probe_next) ph_q <= ph_q + pstep_q;
		end else if (dbusy_q) begin
			div_q <= {div_q[30:0], 1'b0};
			rem_q <= (rem_sh >= 22'(nbits)) ? rem_sh - 22'(nbits) : rem_sh;
		end
	end

	// clear sweep after reset
	logic [WA:0] clr_q;
	assign clr_busy = !clr_q[WA];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) clr_q <= '0;
		else if (clr_busy) clr_q <= clr_q + (WA+1)'(1);
	end
	logic [BW-1:0] pos;
	assign pos = BW'(rem_q);
	logic [WA-1:0] pos_w_q;
	logic [4:0] pos_b_q;
	always_ff @(posedge clk) begin
		if (cmd.mem_rd) begin
			pos_w_q <= WA'(pos >> 5);
			pos_b_q <= pos[4:0];
		end
	end

	logic we;
	logic [WA-1:0] waddr;
	logic [31:0] wdata, rdata;
	assign bit_set = rdata[pos_b_q];
	always_comb begin
		we = 1'b0;
		waddr = pos_w_q;
		wdata = rdata | (32'd1 << pos_b_q);
		if (clr_busy) begin
			we = 1'b1;
			waddr = clr_q[WA-1:0];
			wdata = '0;
		end else if (cmd.mem_chk && mode_q == bfaq_pkg::MODE_ADD) begin
			we = 1'b1;
		end
	end

	bfaq_ram #(.WIDTH(32), .DEPTH(1 << WA)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(cmd.mem_rd ? WA'(pos >> 5) : pos_w_q), .rdata(rdata)
	);

	assign sts.is_last = last_q;
	assign sts.mod_done = dbusy_q && dcnt_q == 6'd31 ? 1'b0 : !dbusy_q;
	assign sts.probes_zero = cmd.fin_mul2 ? (left_q == 5'd0) : (left_q == 5'd1);

	assign done_mode = mode_q;
	assign may_contain = (mode_q == bfaq_pkg::MODE_QUERY) ? allset_q : 1'b0;
endmodule

/* rtl/bloom_filter_add_query.sv */
`timescale 1ns / 1ps
// bloom filter, add and query over a bit store cleared at reset
// request channel: pulse start with mode, key_word, byte_count and last while
// busy is low; a key is a run of such requests, the one with last high ends it.
// each non-last word goes through the scramble multiplies and the absorb step.
// the last word also runs finalization and then each probe in turn, the strobe
// after the last probe: each probe position is reduced by a one-bit-per-cycle
// remainder unit, then the bit word is read and written back through one ram
// port; busy falls right after the strobe cycle.
// result: strobe is high for one cycle with done_mode and may_contain; the
// receiver cannot hold it off. no result for words without last.
// reset: after arst_n rises the store is swept to zero, one 32-bit word a
// cycle, with busy high. configuration writes (cfg_we, cfg_index, cfg_data)
// are taken at any time and are meant for idle.
`include "bloom_filter_add_query_macros.svh"
module bloom_filter_add_query #(
	parameter int STORE_BITS = 65536
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        mode,
	input  logic [31:0] key_word,
	input  logic [2:0]  byte_count,
	input  logic        last,
	output logic        strobe,
	output logic        done_mode,
	output logic        may_contain,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [16:0] cfg_data
);
	bfaq_pkg::dp_cmd_t cmd;
	bfaq_pkg::dp_sts_t sts;
	logic clr_busy;

	bfaq_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .clr_busy(clr_busy),
		.sts(sts), .cmd(cmd), .busy(busy), .strobe(strobe)
	);

	bfaq_dp #(.STORE_BITS(STORE_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts), .clr_busy(clr_busy),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.mode(mode), .key_word(key_word), .byte_count(byte_count), .last(last),
		.done_mode(done_mode), .may_contain(may_contain)
	);

	`BF_IMPLY(a_strobe_busy, clk, arst_n, strobe, busy, "strobe while not busy")
	`BF_IMPLY(a_add_no_hit, clk, arst_n, strobe && !done_mode, !may_contain, "add reported a hit")
	`BF_ASSERT(a_strobe_single, clk, arst_n, strobe |=> !strobe, "strobe held two cycles")
endmodule

/* tb/sv/bloom_query_checker.sv */
`timescale 1ns / 1ps
module bloom_query_checker #(
	parameter int STORE_BITS = 65536
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic        mode,
	input  logic [31:0] key_word,
	input  logic [2:0]  byte_count,
	input  logic        last,
	input  logic        strobe,
	input  logic        done_mode,
	input  logic        may_contain,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [16:0] cfg_data,
	output int          errors,
	output int          pending
);
	localparam int AW = $clog2(STORE_BITS);

	typedef struct packed {
		logic op;
		logic hit;
	} outcome_t;

	logic        filt [0:STORE_BITS-1];
	logic [31:0] acc;
	logic [31:0] key_len;
	logic [16:0] bits_in_use;
	logic [4:0]  probes;
	outcome_t    outcome_q [$];

	function automatic logic [31:0] rol(input logic [31:0] x, input int r);
		return (x << r) | (x >> (32 - r));
	endfunction

	function automatic logic [31:0] scramble_word(input logic [31:0] k);
		logic [31:0] t;
		t = k * bfaq_pkg::C1;
		t = rol(t, 15);
		return t * bfaq_pkg::C2;
	endfunction

	function automatic logic [31:0] mix_block(input logic [31:0] h, input logic [31:0] k);
		logic [31:0] t;
		t = rol(h ^ scramble_word(k), 13);
		return t * 32'd5 + bfaq_pkg::N1;
	endfunction

	function automatic logic [31:0] avalanche(input logic [31:0] h);
		logic [31:0] t;
		t = h ^ (h >> 16);
		t = t * bfaq_pkg::F1;
		t = t ^ (t >> 13);
		t = t * bfaq_pkg::F2;
		return t ^ (t >> 16);
	endfunction

	// absorbs the last word of a key, then runs its probes against the filter copy
	task automatic finish_key(input logic op, input logic [31:0] wd, input logic [2:0] cnt);
		logic [31:0] h;
		logic [31:0] stp;
		logic [31:0] nb;
		logic [31:0] pos;
		logic [2:0]  c;
		logic        all_set;
		outcome_t    o;
		c = (cnt > 3'd4) ? 3'd4 : cnt;
		if (c == 3'd4)
			acc = mix_block(acc, wd);
		else if (c != 3'd0)
			acc = acc ^ scramble_word(wd & ((32'd1 << (8 * c)) - 32'd1));
		key_len = key_len + 32'(c);
		h = avalanche(acc ^ key_len);
		stp = (h >> 17) | (h << 15);
		nb = 32'(bits_in_use);
		if (nb == 0 || nb > STORE_BITS)
			nb = STORE_BITS;
		all_set = 1'b1;
		for (int i = 0; i < int'(probes); i++) begin
			pos = h % nb;
			if (op == bfaq_pkg::MODE_ADD)
				filt[pos[AW-1:0]] = 1'b1;
			else if (!filt[pos[AW-1:0]])
				all_set = 1'b0;
			h = h + stp;
		end
		acc = bfaq_pkg::SEED;
		key_len = '0;
		o.op = op;
		o.hit = (op == bfaq_pkg::MODE_QUERY) ? all_set : 1'b0;
		outcome_q.push_back(o);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < STORE_BITS; i++)
				filt[i] = 1'b0;
			acc = bfaq_pkg::SEED;
			key_len = '0;
			bits_in_use = 17'd65536;
			probes = 5'd7;
			outcome_q.delete();
			errors <= 0;
			pending <= 0;
		end else begin
			if (strobe) begin
				if (outcome_q.size() == 0) begin
					$error("result with no request waiting: done_mode %0d may_contain %0d",
						done_mode, may_contain);
					errors <= errors + 1;
				end else begin
					outcome_t o;
					o = outcome_q.pop_front();
					if (done_mode !== o.op || may_contain !== o.hit)
						errors <= errors + 1;
					if (done_mode !== o.op)
						$error("done_mode: expected %0d, actual %0d", o.op, done_mode);
					if (may_contain !== o.hit)
						$error("may_contain: expected %0d, actual %0d", o.hit, may_contain);
				end
			end
			if (cfg_we) begin
				if (cfg_index == bfaq_pkg::REG_BIT_COUNT)
					bits_in_use = cfg_data;
				else if (cfg_index == bfaq_pkg::REG_HASH_COUNT)
					probes = cfg_data[4:0];
			end
			if (start && !busy) begin
				if (!last) begin
					acc = mix_block(acc, key_word);
					key_len = key_len + 32'd4;
				end else begin
					finish_key(mode, key_word, byte_count);
				end
			end
			pending <= outcome_q.size();
		end
	end
endmodule

/* tb/sv/tb_bloom_filter_add_query.sv */
`timescale 1ns / 1ps
module tb_bloom_filter_add_query;
	localparam int CYCLE_LIMIT = 3000000;
	// index with no register behind it
	localparam logic [1:0] REG_NONE = 2'd3;

	typedef struct {
		logic [31:0] w [0:7];
		int          nw;
		logic [2:0]  tail;
	} bloom_key_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic        mode = 1'b0;
	logic [31:0] key_word = '0;
	logic [2:0]  byte_count = '0;
	logic        last = 1'b0;
	logic        strobe;
	logic        done_mode;
	logic        may_contain;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [16:0] cfg_data = '0;
	int          errors;
	int          pending;
	int          words_sent = 0;
	int          cycles = 0;
	bit          quiet = 0;
	bloom_key_t  added_keys [$];

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	bloom_filter_add_query dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .mode(mode),
		.key_word(key_word), .byte_count(byte_count), .last(last), .strobe(strobe),
		.done_mode(done_mode), .may_contain(may_contain), .cfg_we(cfg_we),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	bloom_query_checker chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .mode(mode),
		.key_word(key_word), .byte_count(byte_count), .last(last), .strobe(strobe),
		.done_mode(done_mode), .may_contain(may_contain), .cfg_we(cfg_we),
		.cfg_index(cfg_index), .cfg_data(cfg_data), .errors(errors), .pending(pending)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	task automatic send_word(input logic m, input logic [31:0] wd, input logic [2:0] bc,
		input logic lst);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		start <= 1'b1;
		mode <= m;
		key_word <= wd;
		byte_count <= bc;
		last <= lst;
		@(posedge clk);
		while (busy) @(posedge clk);
		words_sent++;
	endtask

	// flip marks a key whose earlier words carry the other mode
	task automatic send_key(input logic m, input bloom_key_t k, input bit flip);
		for (int i = 0; i < k.nw - 1; i++)
			send_word(flip ? ~m : m, k.w[i], 3'($urandom_range(0, 7)), 1'b0);
		send_word(m, k.w[k.nw-1], k.tail, 1'b1);
	endtask

	function automatic bloom_key_t rand_key(input int max_words);
		bloom_key_t k;
		for (int i = 0; i < 8; i++)
			k.w[i] = $urandom;
		k.nw = $urandom_range(1, max_words);
		k.tail = (k.nw == 1 && $urandom_range(0, 5) == 0) ? 3'd0 : 3'($urandom_range(1, 7));
		return k;
	endfunction

	task automatic settle;
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_cfg(input logic [1:0] idx, input logic [16:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_traffic(input int n_words, input int max_words);
		bloom_key_t k;
		int goal;
		goal = words_sent + n_words;
		while (words_sent < goal) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: begin
					k = rand_key(max_words);
					send_key(bfaq_pkg::MODE_ADD, k, 1'b0);
					added_keys.push_back(k);
					if (added_keys.size() > 64)
						void'(added_keys.pop_front());
				end
				4, 5, 6, 7: begin
					if (added_keys.size() == 0)
						k = rand_key(max_words);
					else
						k = added_keys[$urandom_range(0, added_keys.size() - 1)];
					send_key(bfaq_pkg::MODE_QUERY, k, 1'b0);
				end
				8: send_key(bfaq_pkg::MODE_QUERY, rand_key(max_words), 1'b0);
				default: send_key(1'($urandom_range(0, 1)), rand_key(max_words), 1'b1);
			endcase
		end
	endtask

	initial begin
		bloom_key_t k;
		logic [16:0] bc_set [7] = '{17'd64, 17'd65536, 17'd0, 17'd100, 17'd131071,
			17'd1000, 17'd4096};
		logic [4:0]  hc_set [7] = '{5'd1, 5'd31, 5'd0, 5'd3, 5'd30, 5'd7, 5'd12};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);

		// directed requests under reset configuration
		k = rand_key(1);
		k.nw = 1;
		k.tail = 3'd0;
		send_key(bfaq_pkg::MODE_QUERY, k, 1'b0);
		send_key(bfaq_pkg::MODE_ADD, k, 1'b0);
		send_key(bfaq_pkg::MODE_QUERY, k, 1'b0);
		for (int i = 0; i < 8; i++)
			k.w[i] = 32'hffffffff;
		k.nw = 3;
		k.tail = 3'd4;
		send_key(bfaq_pkg::MODE_ADD, k, 1'b0);
		send_key(bfaq_pkg::MODE_QUERY, k, 1'b0);
		for (int i = 0; i < 8; i++)
			k.w[i] = '0;
		for (int t = 1; t < 8; t++) begin
			k.nw = 2;
			k.tail = 3'(t);
			send_key(t[0] ? bfaq_pkg::MODE_QUERY : bfaq_pkg::MODE_ADD, k, 1'b0);
		end
		k = rand_key(4);
		send_key(bfaq_pkg::MODE_QUERY, k, 1'b1);
		send_key(bfaq_pkg::MODE_ADD, k, 1'b1);
		send_key(bfaq_pkg::MODE_QUERY, k, 1'b0);
		random_traffic(40, 6);

		for (int p = 0; p < 7; p++) begin
			settle();
			write_cfg(bfaq_pkg::REG_BIT_COUNT, bc_set[p]);
			// upper data bits are ignored by the hash count register
			write_cfg(bfaq_pkg::REG_HASH_COUNT, {12'($urandom), hc_set[p]});
			if (p == 6)
				write_cfg(REG_NONE, 17'h1ffff);
			quiet = (p == 6);
			random_traffic((hc_set[p] > 20) ? 30 : 60, 6);
		end
		settle();
		random_traffic(20, 2);
		settle();
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule

/* bloom_filter_add_query.f */
+incdir+rtl
rtl/bfaq_pkg.sv
rtl/bfaq_ram.sv
rtl/bfaq_ctrl.sv
rtl/bfaq_dp.sv
rtl/bloom_filter_add_query.sv
tb/sv/bloom_query_checker.sv
tb/sv/tb_bloom_filter_add_query.sv
